[design/csm_pkg.sv]
// Package with widths, register codes, types and states of the sensor to motor mapper.
`timescale 1ns / 1ps
package csm_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int SAMPLE_W = 8;
  localparam int DIST_W   = 10;
  localparam int SPEED_W  = 15;
  localparam int BIAS_W   = 9;
  localparam int GAIN_W   = 13;

  localparam int SUM_W   = SAMPLE_W + 1 + COUNT_BITS;
  localparam int MEAN_W  = SAMPLE_W + FRAC_BITS;
  localparam int DVD_W   = SUM_W + FRAC_BITS;
  localparam int DVS_W   = COUNT_BITS + 1;
  localparam int X_W     = SAMPLE_W + FRAC_BITS + 2;
  localparam int P_W     = X_W + GAIN_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int SPEED_MAX = 100;
  localparam logic [SPEED_W-1:0] SPEED_LIM = SPEED_W'(SPEED_MAX << FRAC_BITS);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_BIAS   = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_STOP   = 2'd2;
  localparam logic [1:0] REG_IGNORE = 2'd3;

  localparam logic ACT_PROCESS = 1'b0;
  localparam logic ACT_TOGGLE  = 1'b1;

  typedef struct packed {
    logic signed [BIAS_W-1:0] bias_offset;
    logic signed [GAIN_W-1:0] gain_q8;
    logic [DIST_W-1:0]        stop_distance;
    logic                     ignore_obstacle;
  } csm_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } csm_div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_L,
    S_FIN_L,
    S_MUL_R,
    S_FIN_R,
    S_PUT
  } csm_state_t;

endpackage

[design/csm_if.sv]
// Valid/ready channel interfaces for sample pairs and wheel speed results.
`timescale 1ns / 1ps
interface csm_in_if import csm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;
  logic [DIST_W-1:0]   obstacle_distance;

  modport source (output valid, action, left_sample, right_sample, obstacle_distance,
                  input ready);
  modport sink (input valid, action, left_sample, right_sample, obstacle_distance,
                output ready);
endinterface

interface csm_out_if import csm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic               halt;
  logic               learning;

  modport source (output valid, left_speed, right_speed, halt, learning, input ready);
  modport sink (input valid, left_speed, right_speed, halt, learning, output ready);
endinterface

[design/csm_cfg_regs.sv]
// APB-style configuration registers of the mapper.
`timescale 1ns / 1ps
module csm_cfg_regs import csm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output csm_cfg_t           cfg
);

  csm_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_offset     <= '0;
      cfg_r.gain_q8         <= GAIN_W'(1 << (FRAC_BITS - 1));
      cfg_r.stop_distance   <= DIST_W'(60);
      cfg_r.ignore_obstacle <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_BIAS:   cfg_r.bias_offset     <= pwdata[BIAS_W-1:0];
        REG_GAIN:   cfg_r.gain_q8         <= pwdata[GAIN_W-1:0];
        REG_STOP:   cfg_r.stop_distance   <= pwdata[DIST_W-1:0];
        REG_IGNORE: cfg_r.ignore_obstacle <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BIAS:   prdata = PDATA_W'(cfg_r.bias_offset);
      REG_GAIN:   prdata = PDATA_W'(cfg_r.gain_q8);
      REG_STOP:   prdata = PDATA_W'(cfg_r.stop_distance);
      REG_IGNORE: prdata = PDATA_W'(cfg_r.ignore_obstacle);
      default:    prdata = '0;
    endcase
  end

endmodule

[design/csm_div.sv]
// Restoring divider that forms the mean level one quotient bit per cycle.
`timescale 1ns / 1ps
module csm_div import csm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_W-1:0]      sum,
  input  logic [COUNT_BITS-1:0] count,
  output csm_div_stat_t         stat,
  output logic [MEAN_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(DVD_W);

  logic [DVD_W-1:0]  dq_r, dq_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;
  logic              ge;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;

  assign trial   = {rem_r, dq_r[DVD_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  assign dq_nxt  = {dq_r[DVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= {sum, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      dvs_r <= {count, 1'b0};
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r[MEAN_W-1:0];

endmodule

[design/csm_speed_unit.sv]
// Shared multiply, shift, average and clamp unit that computes one wheel speed at a time.
`timescale 1ns / 1ps
module csm_speed_unit import csm_pkg::*; (
  input  logic                     clk,
  input  logic                     mul_en,
  input  logic [SAMPLE_W-1:0]      sample,
  input  logic [MEAN_W-1:0]        mean,
  input  logic signed [BIAS_W-1:0] bias,
  input  logic signed [GAIN_W-1:0] gain,
  input  logic [SPEED_W-1:0]       prev,
  output logic [SPEED_W-1:0]       speed
);

  localparam int Y_W = P_W - FRAC_BITS;
  localparam int S_W = Y_W + 1;

  logic signed [X_W-1:0] xs, xm, xb, x;
  logic signed [P_W-1:0] p_r;
  logic signed [Y_W-1:0] y;
  logic signed [S_W-1:0] s;
  logic signed [Y_W-1:0] h;

  always_comb begin
    xs = $signed({2'b00, sample, {FRAC_BITS{1'b0}}});
    xm = $signed({2'b00, mean});
    xb = $signed({bias[BIAS_W-1], bias, {FRAC_BITS{1'b0}}});
    x  = xs - xm + xb;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p_r <= x * gain;
    end
  end

  always_comb begin
    y = p_r[P_W-1:FRAC_BITS];
    s = $signed({y[Y_W-1], y}) + $signed({{(S_W-SPEED_W){1'b0}}, prev});
    h = s[S_W-1:1];
    if (h < 0) begin
      speed = '0;
    end else if (h > $signed({{(Y_W-SPEED_W){1'b0}}, SPEED_LIM})) begin
      speed = SPEED_LIM;
    end else begin
      speed = h[SPEED_W-1:0];
    end
  end

endmodule

[design/calibrated_sensor_to_motor_mapper.sv]
// Top level of the calibrated sensor to motor mapper with its sequencer.
//
//   Channel  Direction  Handshake            Carries
//   in_ch    in         valid/ready          action, two samples, distance
//   out_ch   out        valid/ready          two speeds, halt, learning
//   cfg      in         psel/penable/pready  bias, gain, stop distance, ignore
//
// A sample pair in learn mode goes straight to the output state; a pair outside learn mode
// passes through the shared speed unit, which does left then right in two steps each.
// A toggle that leaves learn mode with samples counted waits for the bit-serial
// divider; other toggles are handled in the idle state.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the next result in the sequencer until the output frees.
`timescale 1ns / 1ps
module calibrated_sensor_to_motor_mapper import csm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  csm_in_if.sink             in_ch,
  csm_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  csm_cfg_t      cfg;
  csm_div_stat_t div_stat;
  logic [MEAN_W-1:0] div_q;
  logic          div_start;
  logic          mul_en;
  logic          lane_right;
  logic [SAMPLE_W-1:0] unit_sample;
  logic [SPEED_W-1:0]  unit_prev, unit_speed;
  logic          accept;

  csm_state_t state_r, state_nxt;
  logic learn_r, learn_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [SPEED_W-1:0] lprev_r, lprev_nxt, rprev_r, rprev_nxt;
  logic [SAMPLE_W-1:0] lsmp_r, lsmp_nxt, rsmp_r, rsmp_nxt;
  logic halt_r, halt_nxt, item_learn_r, item_learn_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0] out_l_r, out_l_nxt, out_rs_r, out_rs_nxt;
  logic out_halt_r, out_halt_nxt, out_learn_r, out_learn_nxt;

  csm_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  csm_div u_div (
    .clk, .rst_n, .start(div_start), .sum(sum_r), .count(count_r),
    .stat(div_stat), .quotient(div_q)
  );

  assign unit_sample = lane_right ? rsmp_r : lsmp_r;
  assign unit_prev   = lane_right ? rprev_r : lprev_r;

  csm_speed_unit u_speed (
    .clk, .mul_en, .sample(unit_sample), .mean(mean_r), .bias(cfg.bias_offset),
    .gain(cfg.gain_q8), .prev(unit_prev), .speed(unit_speed)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_speed  = out_l_r;
  assign out_ch.right_speed = out_rs_r;
  assign out_ch.halt        = out_halt_r;
  assign out_ch.learning    = out_learn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      learn_r     <= 1'b1;
      sum_r       <= '0;
      count_r     <= '0;
      mean_r      <= '0;
      lprev_r     <= '0;
      rprev_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      learn_r     <= learn_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      lprev_r     <= lprev_nxt;
      rprev_r     <= rprev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lsmp_r       <= lsmp_nxt;
    rsmp_r       <= rsmp_nxt;
    halt_r       <= halt_nxt;
    item_learn_r <= item_learn_nxt;
    out_l_r      <= out_l_nxt;
    out_rs_r     <= out_rs_nxt;
    out_halt_r   <= out_halt_nxt;
    out_learn_r  <= out_learn_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    learn_nxt      = learn_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    mean_nxt       = mean_r;
    lprev_nxt      = lprev_r;
    rprev_nxt      = rprev_r;
    lsmp_nxt       = lsmp_r;
    rsmp_nxt       = rsmp_r;
    halt_nxt       = halt_r;
    item_learn_nxt = item_learn_r;
    out_l_nxt      = out_l_r;
    out_rs_nxt     = out_rs_r;
    out_halt_nxt   = out_halt_r;
    out_learn_nxt  = out_learn_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    div_start      = 1'b0;
    mul_en         = 1'b0;
    lane_right     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.action == ACT_TOGGLE) begin
            if (!learn_r) begin
              learn_nxt = 1'b1;
            end else if (count_r == '0) begin
              mean_nxt  = '0;
              sum_nxt   = '0;
              learn_nxt = 1'b0;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end else begin
            lsmp_nxt       = in_ch.left_sample;
            rsmp_nxt       = in_ch.right_sample;
            halt_nxt       = (in_ch.obstacle_distance < cfg.stop_distance) &&
                             !cfg.ignore_obstacle;
            item_learn_nxt = learn_r;
            if (learn_r) begin
              if (count_r != COUNT_MAX) begin
                sum_nxt   = sum_r + SUM_W'(in_ch.left_sample) +
                            SUM_W'(in_ch.right_sample);
                count_nxt = count_r + 1'b1;
              end
              lprev_nxt = '0;
              rprev_nxt = '0;
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_MUL_L;
            end
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mean_nxt  = div_q;
          sum_nxt   = '0;
          count_nxt = '0;
          learn_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_MUL_L: begin
        mul_en    = 1'b1;
        state_nxt = S_FIN_L;
      end
      S_FIN_L: begin
        lprev_nxt = unit_speed;
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        lane_right = 1'b1;
        mul_en     = 1'b1;
        state_nxt  = S_FIN_R;
      end
      S_FIN_R: begin
        lane_right = 1'b1;
        rprev_nxt  = unit_speed;
        state_nxt  = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_l_nxt     = lprev_r;
          out_rs_nxt    = rprev_r;
          out_halt_nxt  = halt_r;
          out_learn_nxt = item_learn_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_learn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_learn_r |-> out_l_r == '0 && out_rs_r == '0)
    else $error("nonzero speed reported in learn mode");

  a_speed_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_l_r <= SPEED_LIM && out_rs_r <= SPEED_LIM)
    else $error("speed above limit");

  a_div_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> learn_r && count_r != '0 && (div_stat.busy || div_stat.done))
    else $error("divider running outside a calibration exit");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_stat.done |=> !learn_r && count_r == '0 && sum_r == '0)
    else $error("calibration exit did not clear state");

endmodule

[dv/tb_calibrated_sensor_to_motor_mapper.sv]
// Self-checking testbench for the calibrated sensor to motor mapper with its own speed predictor.
`timescale 1ns / 1ps
module tb_calibrated_sensor_to_motor_mapper;
  import csm_pkg::*;

  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int LONG_CAL_PAIRS  = 120;
  localparam int PHASE_PAIRS     = 130;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic [DIST_W-1:0]   obstacle_distance;
  } sample_pair_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               halt;
    logic               learning;
  } wheel_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  csm_in_if  in_ch ();
  csm_out_if out_ch ();

  calibrated_sensor_to_motor_mapper dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sample_pair_t pairs_to_send[$];
  wheel_cmd_t   commands_expected[$];
  sample_pair_t next_pair;
  wheel_cmd_t   want_cmd;
  logic         pair_taken         = 1'b0;
  int           sender_idle_pct    = 0;
  int           receiver_stall_pct = 0;
  int           hold_off_left      = 0;
  int           failures           = 0;
  logic         gen_learn          = 1'b1;

  csm_cfg_t              cal          = '{bias_offset: '0, gain_q8: 13'sd128,
                                          stop_distance: 10'd60, ignore_obstacle: 1'b0};
  logic                  learning_now = 1'b1;
  logic [SUM_W-1:0]      pair_sum     = '0;
  logic [COUNT_BITS-1:0] pair_count   = '0;
  logic [MEAN_W-1:0]     mean_level   = '0;
  logic [SPEED_W-1:0]    left_prev    = '0;
  logic [SPEED_W-1:0]    right_prev   = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [SPEED_W-1:0] steered_speed(input logic [SAMPLE_W-1:0] sample,
                                                       input logic [SPEED_W-1:0] prev);
    longint centered;
    longint scaled;
    centered = (longint'(sample) <<< FRAC_BITS) - longint'(mean_level)
             + (longint'($signed(cal.bias_offset)) <<< FRAC_BITS);
    scaled = (centered * longint'($signed(cal.gain_q8))) >>> FRAC_BITS;
    scaled = (scaled + longint'(prev)) >>> 1;
    if (scaled < 0) begin
      scaled = 0;
    end else if (scaled > longint'(SPEED_LIM)) begin
      scaled = longint'(SPEED_LIM);
    end
    return SPEED_W'(scaled);
  endfunction

  function automatic void predict_motor_command(input sample_pair_t p);
    wheel_cmd_t cmd;
    if (p.action == ACT_TOGGLE) begin
      if (learning_now) begin
        if (pair_count == 0) begin
          mean_level = '0;
        end else begin
          mean_level = MEAN_W'((longint'(pair_sum) << FRAC_BITS) / (2 * longint'(pair_count)));
        end
        pair_sum   = '0;
        pair_count = '0;
      end
      learning_now = !learning_now;
    end else begin
      if (learning_now) begin
        if (pair_count != COUNT_MAX) begin
          pair_sum   = pair_sum + SUM_W'(p.left_sample) + SUM_W'(p.right_sample);
          pair_count = pair_count + 1'b1;
        end
        cmd.left_speed  = '0;
        cmd.right_speed = '0;
      end else begin
        cmd.left_speed  = steered_speed(p.left_sample, left_prev);
        cmd.right_speed = steered_speed(p.right_sample, right_prev);
      end
      left_prev    = cmd.left_speed;
      right_prev   = cmd.right_speed;
      cmd.halt     = (p.obstacle_distance < cal.stop_distance) && !cal.ignore_obstacle;
      cmd.learning = learning_now;
      commands_expected.push_back(cmd);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [SPEED_W-1:0] want,
                                        input logic [SPEED_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || pair_taken) begin
      pair_taken = 1'b0;
      if (pairs_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_pair               = pairs_to_send.pop_front();
        in_ch.valid             <= 1'b1;
        in_ch.action            <= next_pair.action;
        in_ch.left_sample       <= next_pair.left_sample;
        in_ch.right_sample      <= next_pair.right_sample;
        in_ch.obstacle_distance <= next_pair.obstacle_distance;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_ch.ready  <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_motor_command('{in_ch.action, in_ch.left_sample, in_ch.right_sample,
                                in_ch.obstacle_distance});
        pair_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (commands_expected.size() == 0) begin
          $error("Result arrived with no sample pair waiting for one.");
          failures++;
        end else begin
          want_cmd = commands_expected.pop_front();
          compare_field("left_speed", want_cmd.left_speed, out_ch.left_speed);
          compare_field("right_speed", want_cmd.right_speed, out_ch.right_speed);
          compare_field("halt", SPEED_W'(want_cmd.halt), SPEED_W'(out_ch.halt));
          compare_field("learning", SPEED_W'(want_cmd.learning), SPEED_W'(out_ch.learning));
        end
      end
    end
  end

  function automatic void queue_pair(input logic action, input logic [SAMPLE_W-1:0] l,
                                     input logic [SAMPLE_W-1:0] r, input logic [DIST_W-1:0] d);
    pairs_to_send.push_back(sample_pair_t'{action, l, r, d});
    if (action == ACT_TOGGLE) begin
      gen_learn = !gen_learn;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int center);
    int s;
    if ($urandom_range(1) == 1) begin
      return SAMPLE_W'($urandom_range(255));
    end
    s = center + int'($urandom_range(40)) - 20;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return SAMPLE_W'(s);
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance();
    int d;
    if ($urandom_range(99) < 65) begin
      return DIST_W'($urandom_range(1023));
    end
    d = int'(cal.stop_distance) + int'($urandom_range(4)) - 2;
    if (d < 0) d = 0;
    if (d > 1023) d = 1023;
    return DIST_W'(d);
  endfunction

  function automatic void random_pairs(input int n);
    int center;
    center = $urandom_range(255);
    repeat (n) begin
      if ((gen_learn && $urandom_range(99) < 12) || (!gen_learn && $urandom_range(99) < 3)) begin
        queue_pair(ACT_TOGGLE, SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)),
                   DIST_W'($urandom_range(1023)));
      end else begin
        queue_pair(ACT_PROCESS, pick_sample(center), pick_sample(center), pick_distance());
      end
    end
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pairs_to_send.size() != 0 || in_ch.valid || commands_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_BIAS:   cal.bias_offset     = value[BIAS_W-1:0];
      REG_GAIN:   cal.gain_q8         = value[GAIN_W-1:0];
      REG_STOP:   cal.stop_distance   = value[DIST_W-1:0];
      REG_IGNORE: cal.ignore_obstacle = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int bias, input int gain, input int stop, input int ignore);
    write_reg(REG_BIAS, PDATA_W'(bias));
    write_reg(REG_GAIN, PDATA_W'(gain));
    write_reg(REG_STOP, PDATA_W'(stop));
    write_reg(REG_IGNORE, PDATA_W'(ignore));
  endtask

  task automatic run_phase(input int mode, input int n, input bit with_hold_off);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
      default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
    endcase
    random_pairs(n);
    if (with_hold_off) begin
      @(posedge clk);
      #1;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    wait_drained();
  endtask

  initial begin
    #(40_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int gain;
    rst_n                   = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    in_ch.valid             = 1'b0;
    in_ch.action            = ACT_PROCESS;
    in_ch.left_sample       = '0;
    in_ch.right_sample      = '0;
    in_ch.obstacle_distance = '0;
    out_ch.ready            = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Leaving learn mode with nothing counted, then the field extremes.
    queue_pair(ACT_TOGGLE, 8'd255, 8'd255, 10'd1023);
    queue_pair(ACT_PROCESS, 8'd0, 8'd0, 10'd0);
    queue_pair(ACT_PROCESS, 8'd255, 8'd255, 10'd59);
    queue_pair(ACT_PROCESS, 8'd255, 8'd0, 10'd60);
    queue_pair(ACT_PROCESS, 8'd0, 8'd255, 10'd1023);
    queue_pair(ACT_PROCESS, 8'd128, 8'd64, 10'd512);
    // Back into learn mode, a short calibration, then out with a real mean.
    queue_pair(ACT_TOGGLE, 8'd0, 8'd0, 10'd0);
    queue_pair(ACT_PROCESS, 8'd255, 8'd255, 10'd0);
    queue_pair(ACT_PROCESS, 8'd0, 8'd0, 10'd1023);
    queue_pair(ACT_PROCESS, 8'd200, 8'd17, 10'd61);
    queue_pair(ACT_TOGGLE, 8'd170, 8'd85, 10'd682);
    queue_pair(ACT_PROCESS, 8'd255, 8'd255, 10'd100);
    queue_pair(ACT_PROCESS, 8'd0, 8'd0, 10'd5);
    queue_pair(ACT_PROCESS, 8'd100, 8'd200, 10'd59);
    queue_pair(ACT_PROCESS, 8'd85, 8'd170, 10'd341);
    wait_drained();

    for (int s = 0; s < 9; s++) begin
      case (s)
        0: configure(0, 128, 60, 0);
        1: configure(-255, -4096, 0, 0);
        2: configure(255, 4095, 1023, 0);
        3: configure(-40, 300, 1023, 1);
        default: begin
          if ($urandom_range(1) == 1) begin
            gain = int'($urandom_range(8191)) - 4096;
          end else begin
            gain = int'($urandom_range(1024)) - 512;
          end
          configure(int'($urandom_range(510)) - 255, gain, $urandom_range(1023),
                    $urandom_range(1));
        end
      endcase
      run_phase(s % 4, PHASE_PAIRS, s == 4);
    end

    // A longer calibration over random samples, then steering with its mean.
    configure(0, 128, 60, 0);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    if (!gen_learn) begin
      queue_pair(ACT_TOGGLE, SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)),
                 DIST_W'($urandom_range(1023)));
    end
    repeat (LONG_CAL_PAIRS) begin
      queue_pair(ACT_PROCESS, SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)),
                 DIST_W'($urandom_range(1023)));
    end
    queue_pair(ACT_TOGGLE, SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)),
               DIST_W'($urandom_range(1023)));
    random_pairs(40);
    wait_drained();

    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/csm_pkg.sv
design/csm_if.sv
design/csm_cfg_regs.sv
design/csm_div.sv
design/csm_speed_unit.sv
design/calibrated_sensor_to_motor_mapper.sv
dv/tb_calibrated_sensor_to_motor_mapper.sv
